/* sv/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int DEFAULT_DEPTH          = 16;
    localparam int DEFAULT_ITEM_WIDTH     = 32;
    localparam int DEFAULT_PRIORITY_WIDTH = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } spq_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] item_in;
        logic [31:0] priority_in;
    } spq_cmd_t;

    typedef struct packed {
        logic [31:0] item_out;
        logic [31:0] priority_out;
        logic [1:0]  status;
        logic        queue_empty;
        logic [4:0]  entry_count;
    } spq_result_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } spq_ctrl_t;

endpackage

/* sv/spq_cell.sv */
// One queue cell: holds an entry and shifts toward either neighbor.
module spq_cell
    import spq_pkg::*;
#(
    parameter int ITEM_WIDTH     = DEFAULT_ITEM_WIDTH,
    parameter int PRIORITY_WIDTH = DEFAULT_PRIORITY_WIDTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  spq_ctrl_t                 ctrl,
    input  logic [ITEM_WIDTH-1:0]     new_item,
    input  logic [PRIORITY_WIDTH-1:0] new_prio,
    input  logic                      left_valid,
    input  logic                      left_keep,
    input  logic [ITEM_WIDTH-1:0]     left_item,
    input  logic [PRIORITY_WIDTH-1:0] left_prio,
    input  logic                      right_valid,
    input  logic [ITEM_WIDTH-1:0]     right_item,
    input  logic [PRIORITY_WIDTH-1:0] right_prio,
    output logic                      valid,
    output logic                      keep,
    output logic [ITEM_WIDTH-1:0]     item,
    output logic [PRIORITY_WIDTH-1:0] prio
);

    logic                      valid_reg, valid_next;
    logic [ITEM_WIDTH-1:0]     item_reg, item_next;
    logic [PRIORITY_WIDTH-1:0] prio_reg, prio_next;

    // entry stays in place on insert: new one goes after it
    assign keep  = valid_reg && (prio_reg <= new_prio);
    assign valid = valid_reg;
    assign item  = item_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        prio_next  = prio_reg;
        if (ctrl.insert && !keep)
        begin
            if (left_keep)
            begin
                valid_next = 1'b1;
                item_next  = new_item;
                prio_next  = new_prio;
            end
            else
            begin
                valid_next = left_valid;
                item_next  = left_item;
                prio_next  = left_prio;
            end
        end
        else if (ctrl.remove)
        begin
            valid_next = right_valid;
            item_next  = right_item;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prio_reg <= prio_next;
    end

endmodule

/* sv/sorted_priority_queue_core.sv */
// Top level of the sorted min-first priority queue built from a row of cells.
//
//  channel   ports                  handshake
//  command   cmd (spq_cmd_t)        taken when start && !busy
//  result    result (spq_result_t)  shown for one cycle with done
//
//  One item per cycle: the cells compare against the new priority in parallel
//  and shift in the same clock, so busy stays low.
//  The result appears in the cycle after the item is taken.
//  Reset clears all valid bits and the entry count; no clearing pass.
//  The receiver cannot stall the result.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH          = DEFAULT_DEPTH,
    parameter int ITEM_WIDTH     = DEFAULT_ITEM_WIDTH,
    parameter int PRIORITY_WIDTH = DEFAULT_PRIORITY_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  spq_cmd_t    cmd,
    output logic        done,
    output spq_result_t result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                      valid_w [DEPTH];
    logic                      keep_w  [DEPTH];
    logic [ITEM_WIDTH-1:0]     item_w  [DEPTH];
    logic [PRIORITY_WIDTH-1:0] prio_w  [DEPTH];

    logic [ITEM_WIDTH-1:0]     new_item;
    logic [PRIORITY_WIDTH-1:0] new_prio;
    spq_ctrl_t                 ctrl;
    logic                      accept;
    logic                      full;
    logic                      empty;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    spq_result_t      result_reg, result_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign full     = valid_w[DEPTH-1];
    assign empty    = !valid_w[0];
    assign new_item = ITEM_WIDTH'(cmd.item_in);
    assign new_prio = PRIORITY_WIDTH'(cmd.priority_in);

    assign ctrl.insert = accept && (cmd.opcode == OP_INSERT) && !full;
    assign ctrl.remove = accept && (cmd.opcode == OP_REMOVE) && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                      l_valid, l_keep, r_valid;
            logic [ITEM_WIDTH-1:0]     l_item, r_item;
            logic [PRIORITY_WIDTH-1:0] l_prio, r_prio;

            if (i == 0)
            begin : g_head
                assign l_valid = 1'b1;
                assign l_keep  = 1'b1;
                assign l_item  = new_item;
                assign l_prio  = new_prio;
            end
            else
            begin : g_mid
                assign l_valid = valid_w[i-1];
                assign l_keep  = keep_w[i-1];
                assign l_item  = item_w[i-1];
                assign l_prio  = prio_w[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_item  = item_w[i];
                assign r_prio  = prio_w[i];
            end
            else
            begin : g_body
                assign r_valid = valid_w[i+1];
                assign r_item  = item_w[i+1];
                assign r_prio  = prio_w[i+1];
            end

            spq_cell #(
                .ITEM_WIDTH     (ITEM_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_item    (new_item),
                .new_prio    (new_prio),
                .left_valid  (l_valid),
                .left_keep   (l_keep),
                .left_item   (l_item),
                .left_prio   (l_prio),
                .right_valid (r_valid),
                .right_item  (r_item),
                .right_prio  (r_prio),
                .valid       (valid_w[i]),
                .keep        (keep_w[i]),
                .item        (item_w[i]),
                .prio        (prio_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        result_next = result_reg;
        done_next   = accept;
        if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (accept)
        begin
            result_next.item_out     = '0;
            result_next.priority_out = '0;
            result_next.status       = ST_OK;
            if (ctrl.remove)
            begin
                result_next.item_out     = 32'(item_w[0]);
                result_next.priority_out = 32'(prio_w[0]);
            end
            else if (cmd.opcode == OP_REMOVE)
            begin
                result_next.status = ST_EMPTY;
            end
            else if (!ctrl.insert)
            begin
                result_next.status = ST_FULL;
            end
            result_next.queue_empty = (count_next == '0);
            result_next.entry_count = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* sv/spq_checker.sv */
// Port-level checks for the priority queue, bound to the top level.
module spq_checker
    import spq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input spq_cmd_t    cmd,
    input logic        done,
    input spq_result_t result
);

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("accepted item gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without an accepted item");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_EMPTY || result.status == ST_FULL)
            |-> result.item_out == '0 && result.priority_out == '0)
        else $error("failed step reports a nonzero entry");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_EMPTY |-> result.queue_empty)
        else $error("remove from empty queue but queue not empty");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
